// ----- rtl/core/wwd_pkg.sv -----
// Shared types, constants and scoring helpers for the weighted worker dispatcher.
// Used by wwd_div and weighted_worker_dispatcher_unit; no dependencies.
package wwd_pkg;

  localparam int MOD_W  = 3;
  localparam int TIME_W = 24;
  localparam int Q_W    = 16;
  localparam int LOAD_W = 17;
  localparam int ACT_W  = 16;
  localparam int CNT_W  = 32;
  localparam int KEY_W  = 32;
  localparam int SCORE_W = 25;

  localparam int DIV_NW = 49;
  localparam int DIV_DW = 32;

  localparam logic [TIME_W-1:0] TIME_CAP  = 24'd25600;
  localparam logic [LOAD_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0]       ALPHA     = 17'd13107;
  localparam logic [16:0]       ALPHA_C   = 17'd52429;
  localparam logic [Q_W-1:0]    Q_MAX     = 16'hFFFF;
  localparam logic [7:0]        CONF_HALF = 8'd250;
  // Divide by 500 as multiply by ceil(2^34 / 500), then shift by 34;
  // exact for every dividend below 2^25
  localparam logic [25:0]       CONF_RECIP = 26'd34359739;
  localparam int                CONF_SHIFT = 34;

  typedef enum logic [1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_REGISTER = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STRAT_QUALITY = 3'd0,
    STRAT_LATENCY = 3'd1,
    STRAT_LOAD    = 3'd2,
    STRAT_SCORE   = 3'd3,
    STRAT_FEWEST  = 3'd4
  } strategy_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_OVERLOAD = 2'd2,
    ST_NOT_REG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_STRATEGY   = 2'd0,
    CFG_LOAD_LIMIT = 2'd1,
    CFG_MAX_ACTIVE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_RDW,
    S_MUL,
    S_DR_GO,
    S_DR_WAIT,
    S_DL_GO,
    S_DL_WAIT,
    S_DC_GO,
    S_DC_WAIT,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [MOD_W-1:0]  caps;
    logic              open;
    logic [ACT_W-1:0]  active;
    logic [CNT_W-1:0]  done;
    logic [TIME_W-1:0] avg_time;
    logic [Q_W-1:0]    avg_qual;
    logic [Q_W-1:0]    ratio;
    logic [LOAD_W-1:0] load;
    logic [CNT_W-1:0]  disp;
  } slot_rec_t;

  // Weighted score times 500, in Q0.16 units
  function automatic logic [SCORE_W-1:0] score_num(slot_rec_t r);
    logic [TIME_W-1:0] t;
    logic [SCORE_W-1:0] s;
    t = (r.avg_time > TIME_CAP) ? TIME_CAP : r.avg_time;
    s = SCORE_W'(r.avg_qual) * SCORE_W'(150)
      + SCORE_W'(TIME_CAP - t) * SCORE_W'(320)
      + SCORE_W'(ONE_Q16 - r.load) * SCORE_W'(125)
      + SCORE_W'(r.ratio) * SCORE_W'(100);
    return s;
  endfunction

  function automatic logic [TIME_W-1:0] ema(logic [TIME_W-1:0] old, logic [TIME_W-1:0] x);
    logic [41:0] v;
    v = 42'(old) * 42'(ALPHA_C) + 42'(x) * 42'(ALPHA) + 42'd32768;
    return v[39:16];
  endfunction

  // Lower key wins under every strategy
  function automatic logic [KEY_W-1:0] key_of(logic [2:0] strat, slot_rec_t r);
    logic [KEY_W-1:0] k;
    case (strat)
      STRAT_QUALITY: k = KEY_W'(Q_MAX - r.avg_qual);
      STRAT_LATENCY: k = KEY_W'(r.avg_time);
      STRAT_LOAD:    k = KEY_W'(r.load);
      STRAT_FEWEST:  k = r.disp;
      default:       k = KEY_W'({SCORE_W{1'b1}} - score_num(r));
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/wwd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on wwd_pkg for operand widths.
module wwd_div import wwd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0]   rem_r, rem_nxt;
  logic [DIV_NW-1:0]   quo_r, quo_nxt;
  logic [DIV_DW-1:0]   dvs_r, dvs_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [DIV_DW:0]     trial;
  logic                fits;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NW-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_BITS'(DIV_NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? DIV_DW'(trial - {1'b0, dvs_r}) : trial[DIV_DW-1:0];
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/weighted_worker_dispatcher_unit.sv -----
// Weighted worker dispatcher: slot record memory, scan pipeline and sequencer.
// Depends on wwd_pkg and wwd_div.
//
// Usage:
//   Input channel (in_*): one transaction per item; kind selects dispatch,
//   complete, register slot or no operation. Result channel (out_*): exactly
//   one transaction per input item, in order. Configuration (cfg_*): always
//   ready; write strategy, load limit and task limit while the block is idle.
// Sequencing (in_ready returns with out_valid):
//   One item at a time. Complete: two passes through the 49-step shared
//   divider (success ratio, then load); one pass with a zero task limit.
//   Dispatch: a scan of all slots (one slot read per cycle), one divider pass
//   for the load and a reciprocal multiply for the confidence.
// Reset:
//   Synchronous, active low. All slots read as unregistered with zero counts
//   at once (valid bit per slot); config returns to strategy 3, load limit
//   52429, task limit 4. No clearing pass.
// Stall:
//   A finished result waits in the output register until out_ready drains it.
//   The sequencer goes idle on loading it; a later item holds in S_DONE until then.
module weighted_worker_dispatcher_unit import wwd_pkg::*; #(
  parameter int SLOT_COUNT    = 16,
  parameter int MODALITY_BITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [2:0]  in_modality_mask,
  input  logic        in_available,
  input  logic [23:0] in_time_value,
  input  logic [15:0] in_quality_value,
  input  logic        in_task_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chosen_slot,
  output logic [16:0] out_confidence,
  output logic [23:0] out_est_time,
  output logic [15:0] out_est_quality,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Configuration registers
  logic [2:0]        strategy_r;
  logic [LOAD_W-1:0] load_limit_r;
  logic [ACT_W-1:0]  max_active_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r   <= STRAT_SCORE;
      load_limit_r <= 17'd52429;
      max_active_r <= 16'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STRATEGY:   strategy_r   <= cfg_data[2:0];
        CFG_LOAD_LIMIT: load_limit_r <= cfg_data;
        CFG_MAX_ACTIVE: max_active_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_t            state_r, state_nxt;
  kind_t             op_kind_r, op_kind_nxt;
  logic [3:0]        op_slot_r, op_slot_nxt;
  logic [MOD_W-1:0]  op_mm_r, op_mm_nxt;
  logic              op_av_r, op_av_nxt;
  logic [TIME_W-1:0] op_tv_r, op_tv_nxt;
  logic [Q_W-1:0]    op_qv_r, op_qv_nxt;
  logic              op_ok_r, op_ok_nxt;

  slot_rec_t         rec_r, rec_nxt;
  logic [47:0]       prod_r, prod_nxt;

  logic [SLOT_W:0]   scan_cnt_r, scan_cnt_nxt;
  logic              p1_vld_r, p1_vld_nxt;
  logic [SLOT_W-1:0] p1_idx_r, p1_idx_nxt;
  logic              p2_vld_r, p2_vld_nxt;
  logic              p2_ok_r, p2_ok_nxt;
  logic [SLOT_W-1:0] p2_idx_r, p2_idx_nxt;
  logic [KEY_W-1:0]  p2_key_r, p2_key_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] best_idx_r, best_idx_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;

  logic              res_acc_r, res_acc_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [3:0]        res_slot_r, res_slot_nxt;
  logic [LOAD_W-1:0] res_conf_r, res_conf_nxt;
  logic [TIME_W-1:0] res_time_r, res_time_nxt;
  logic [Q_W-1:0]    res_qual_r, res_qual_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [3:0]        out_slot_r, out_slot_nxt;
  logic [LOAD_W-1:0] out_conf_r, out_conf_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic [Q_W-1:0]    out_qual_r, out_qual_nxt;

  // Slot record memory with per-slot valid bits
  slot_rec_t                mem [SLOT_COUNT];
  slot_rec_t                mem_q_r;
  logic [SLOT_COUNT-1:0]    valid_r;
  logic                     vq_r;
  logic [SLOT_W-1:0]        mem_ra, mem_wa, tgt_idx;
  logic                     mem_we;
  slot_rec_t                rd_rec;

  // Shared divider
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  wwd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic [MOD_W-1:0] mm_mask;
  logic             in_fire;
  logic             slot_oob;
  logic [TIME_W-1:0] qual_ema;
  // Confidence: rounded score times the reciprocal of 500
  logic [50:0]       conf_prod;
  logic [LOAD_W-1:0] conf_q;

  always_comb begin
    for (int i = 0; i < MOD_W; i++) begin
      mm_mask[i] = (i < MODALITY_BITS);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign slot_oob = (32'(in_slot) >= SLOT_COUNT);
  assign tgt_idx  = (op_kind_r == KIND_DISPATCH) ? best_idx_r : SLOT_W'(op_slot_r);
  assign rd_rec   = vq_r ? mem_q_r : '0;
  assign mem_wa   = tgt_idx;
  assign qual_ema = ema(TIME_W'(rd_rec.avg_qual), TIME_W'(op_qv_r));
  assign conf_prod = 51'(prod_r[SCORE_W-1:0]) * 51'(CONF_RECIP);
  assign conf_q    = conf_prod[CONF_SHIFT +: LOAD_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= rec_r;
    end
    mem_q_r <= mem[mem_ra];
    vq_r    <= valid_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_wa] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_kind_nxt    = op_kind_r;
    op_slot_nxt    = op_slot_r;
    op_mm_nxt      = op_mm_r;
    op_av_nxt      = op_av_r;
    op_tv_nxt      = op_tv_r;
    op_qv_nxt      = op_qv_r;
    op_ok_nxt      = op_ok_r;
    rec_nxt        = rec_r;
    prod_nxt       = prod_r;
    scan_cnt_nxt   = scan_cnt_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    res_acc_nxt    = res_acc_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_conf_nxt   = res_conf_r;
    res_time_nxt   = res_time_r;
    res_qual_nxt   = res_qual_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_acc_nxt    = out_acc_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_conf_nxt   = out_conf_r;
    out_time_nxt   = out_time_r;
    out_qual_nxt   = out_qual_r;
    mem_ra         = tgt_idx;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;

    // Scan pipeline: read, then key, then compare
    p1_vld_nxt = 1'b0;
    p1_idx_nxt = scan_cnt_r[SLOT_W-1:0];
    p2_vld_nxt = p1_vld_r;
    p2_idx_nxt = p1_idx_r;
    p2_ok_nxt  = rd_rec.open && ((op_mm_r & ~rd_rec.caps) == '0);
    p2_key_nxt = key_of(strategy_r, rd_rec);

    if (p2_vld_r && p2_ok_r && (!found_r || (p2_key_r < best_key_r))) begin
      found_nxt    = 1'b1;
      best_idx_nxt = p2_idx_r;
      best_key_nxt = p2_key_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_kind_nxt    = kind_t'(in_kind);
          op_slot_nxt    = in_slot;
          op_mm_nxt      = in_modality_mask & mm_mask;
          op_av_nxt      = in_available;
          op_tv_nxt      = in_time_value;
          op_qv_nxt      = in_quality_value;
          op_ok_nxt      = in_task_ok;
          res_acc_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_conf_nxt   = '0;
          res_time_nxt   = '0;
          res_qual_nxt   = '0;
          scan_cnt_nxt   = '0;
          found_nxt      = 1'b0;
          case (kind_t'(in_kind))
            KIND_DISPATCH: state_nxt = S_SCAN;
            KIND_COMPLETE, KIND_REGISTER: begin
              if (slot_oob) begin
                res_status_nxt = ST_NOT_REG;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        if (32'(scan_cnt_r) < SLOT_COUNT) begin
          mem_ra       = scan_cnt_r[SLOT_W-1:0];
          p1_vld_nxt   = 1'b1;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else if (!p1_vld_r && !p2_vld_r) begin
          if (!found_r) begin
            res_status_nxt = ST_NO_SLOT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rec_nxt = rd_rec;
        case (op_kind_r)
          KIND_DISPATCH: begin
            if ((rd_rec.load < load_limit_r) && (rd_rec.active < max_active_r)) begin
              rec_nxt.active = rd_rec.active + 1'b1;
              rec_nxt.disp   = rd_rec.disp + 1'b1;
              state_nxt      = S_DL_GO;
            end else begin
              res_status_nxt = ST_OVERLOAD;
              res_slot_nxt   = 4'(best_idx_r);
              state_nxt      = S_DONE;
            end
          end
          KIND_COMPLETE: begin
            if (!vq_r) begin
              res_status_nxt = ST_NOT_REG;
              state_nxt      = S_DONE;
            end else begin
              rec_nxt.avg_time = ema(rd_rec.avg_time, op_tv_r);
              rec_nxt.avg_qual = qual_ema[Q_W-1:0];
              if (rd_rec.done != '1) begin
                rec_nxt.done = rd_rec.done + 1'b1;
              end
              if (rd_rec.active != '0) begin
                rec_nxt.active = rd_rec.active - 1'b1;
              end
              state_nxt = S_MUL;
            end
          end
          default: begin
            rec_nxt.caps     = op_mm_r;
            rec_nxt.open     = op_av_r;
            rec_nxt.avg_time = op_tv_r;
            rec_nxt.avg_qual = op_qv_r;
            res_acc_nxt      = 1'b1;
            state_nxt        = S_WR;
          end
        endcase
      end

      S_MUL: begin
        prod_nxt  = 48'(rec_r.ratio) * 48'(rec_r.done - 1'b1);
        state_nxt = S_DR_GO;
      end

      S_DR_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_NW'(prod_r) + (op_ok_r ? DIV_NW'(ONE_Q16) : '0)
                     + DIV_NW'(rec_r.done >> 1);
        div_divisor  = rec_r.done;
        state_nxt    = S_DR_WAIT;
      end

      S_DR_WAIT: begin
        if (div_done) begin
          rec_nxt.ratio = (div_quo > DIV_NW'(Q_MAX)) ? Q_MAX : div_quo[Q_W-1:0];
          state_nxt     = S_DL_GO;
        end
      end

      S_DL_GO: begin
        if (max_active_r == '0) begin
          rec_nxt.load = ONE_Q16;
          if (op_kind_r == KIND_DISPATCH) begin
            state_nxt = S_DC_GO;
          end else begin
            res_acc_nxt = 1'b1;
            state_nxt   = S_WR;
          end
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_NW'({rec_r.active, 16'h0000});
          div_divisor  = DIV_DW'(max_active_r);
          state_nxt    = S_DL_WAIT;
        end
      end

      S_DL_WAIT: begin
        if (div_done) begin
          rec_nxt.load = (div_quo > DIV_NW'(ONE_Q16)) ? ONE_Q16 : div_quo[LOAD_W-1:0];
          if (op_kind_r == KIND_DISPATCH) begin
            state_nxt = S_DC_GO;
          end else begin
            res_acc_nxt = 1'b1;
            state_nxt   = S_WR;
          end
        end
      end

      S_DC_GO: begin
        // Register the rounded score; the multiply follows next cycle
        prod_nxt  = 48'(score_num(rec_r)) + 48'(CONF_HALF);
        state_nxt = S_DC_WAIT;
      end

      S_DC_WAIT: begin
        res_conf_nxt   = (conf_q > ONE_Q16) ? ONE_Q16 : conf_q;
        res_acc_nxt    = 1'b1;
        res_status_nxt = ST_OK;
        res_slot_nxt   = 4'(best_idx_r);
        res_time_nxt   = rec_r.avg_time;
        res_qual_nxt   = rec_r.avg_qual;
        state_nxt      = S_WR;
      end

      S_WR: begin
        mem_we    = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = res_acc_r;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_conf_nxt   = res_conf_r;
          out_time_nxt   = res_time_r;
          out_qual_nxt   = res_qual_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p2_vld_nxt;
      found_r     <= found_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_kind_r    <= op_kind_nxt;
    op_slot_r    <= op_slot_nxt;
    op_mm_r      <= op_mm_nxt;
    op_av_r      <= op_av_nxt;
    op_tv_r      <= op_tv_nxt;
    op_qv_r      <= op_qv_nxt;
    op_ok_r      <= op_ok_nxt;
    rec_r        <= rec_nxt;
    prod_r       <= prod_nxt;
    p1_idx_r     <= p1_idx_nxt;
    p2_idx_r     <= p2_idx_nxt;
    p2_ok_r      <= p2_ok_nxt;
    p2_key_r     <= p2_key_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    res_acc_r    <= res_acc_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_conf_r   <= res_conf_nxt;
    res_time_r   <= res_time_nxt;
    res_qual_r   <= res_qual_nxt;
    out_acc_r    <= out_acc_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_conf_r   <= out_conf_nxt;
    out_time_r   <= out_time_nxt;
    out_qual_r   <= out_qual_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_status      = out_status_r;
  assign out_chosen_slot = out_slot_r;
  assign out_confidence  = out_conf_r;
  assign out_est_time    = out_time_r;
  assign out_est_quality = out_qual_r;

endmodule

// ----- tb/sv/tb_weighted_worker_dispatcher_unit.sv -----
// Self-checking testbench for weighted_worker_dispatcher_unit: queued stimulus,
// a slot-table predictor and an in-order result scoreboard. Depends on wwd_pkg.
`timescale 1ns / 100ps
module tb_weighted_worker_dispatcher_unit;
  import wwd_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [2:0]  mask;
    logic        avail;
    logic [23:0] tval;
    logic [15:0] qval;
    logic        ok;
  } job_t;

  typedef struct {
    logic        accepted;
    logic [1:0]  status;
    logic [3:0]  chosen;
    logic [16:0] conf;
    logic [23:0] est_time;
    logic [15:0] est_qual;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [3:0] in_slot = '0;
  logic [2:0] in_modality_mask = '0;
  logic in_available = 1'b0;
  logic [23:0] in_time_value = '0;
  logic [15:0] in_quality_value = '0;
  logic in_task_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  logic [1:0] out_status;
  logic [3:0] out_chosen_slot;
  logic [16:0] out_confidence;
  logic [23:0] out_est_time;
  logic [15:0] out_est_quality;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  weighted_worker_dispatcher_unit dut (.*);

  always #2 clk = ~clk;

  // Pending jobs, expected verdicts and handshake bookkeeping
  job_t     pending_jobs[$];
  verdict_t expected_verdicts[$];
  int unsigned jobs_sent = 0;
  int unsigned jobs_taken = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit failed = 0;

  // Add to the tail of the stimulus and expectation queues
  function automatic void append_job(job_t j);
    pending_jobs = {pending_jobs, j};
  endfunction

  function automatic void append_verdict(verdict_t v);
    expected_verdicts = {expected_verdicts, v};
  endfunction

  // Predictor copy of configuration and slot table
  logic [2:0]  cur_strategy;
  logic [16:0] cur_load_limit;
  logic [15:0] cur_max_active;
  logic        t_valid[NSLOT];
  logic [2:0]  t_caps[NSLOT];
  logic        t_open[NSLOT];
  logic [15:0] t_active[NSLOT];
  logic [31:0] t_done[NSLOT];
  logic [23:0] t_time[NSLOT];
  logic [15:0] t_qual[NSLOT];
  logic [15:0] t_ratio[NSLOT];
  logic [16:0] t_load[NSLOT];
  logic [31:0] t_disp[NSLOT];

  function automatic logic [16:0] load_for(logic [15:0] act);
    longint unsigned l;
    if (cur_max_active == 0) return 17'd65536;
    l = (longint'(act) << 16) / cur_max_active;
    return (l > 65536) ? 17'd65536 : 17'(l);
  endfunction

  // Weighted score scaled by 500
  function automatic longint unsigned weighted_score(int s);
    longint unsigned t;
    t = (t_time[s] > 25600) ? 25600 : t_time[s];
    return longint'(t_qual[s]) * 150 + (25600 - t) * 320
         + (65536 - longint'(t_load[s])) * 125 + longint'(t_ratio[s]) * 100;
  endfunction

  function automatic logic [23:0] smooth(logic [23:0] old, logic [23:0] x);
    longint unsigned v;
    v = longint'(old) * 52429 + longint'(x) * 13107 + 32768;
    return 24'(v >> 16);
  endfunction

  function automatic bit outranks(int a, int b);
    case (cur_strategy)
      STRAT_QUALITY: return t_qual[a] > t_qual[b];
      STRAT_LATENCY: return t_time[a] < t_time[b];
      STRAT_LOAD:    return t_load[a] < t_load[b];
      STRAT_FEWEST:  return t_disp[a] < t_disp[b];
      default:       return weighted_score(a) > weighted_score(b);
    endcase
  endfunction

  function automatic verdict_t dispatch_outcome(job_t j);
    verdict_t r;
    int best;
    bit found;
    longint unsigned sc, num;
    int s;
    r = '{default: '0};
    best = 0;
    found = 1'b0;
    s = j.slot;
    case (j.kind)
      KIND_DISPATCH: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (t_valid[i] && t_open[i] && ((j.mask & ~t_caps[i]) == 3'd0)) begin
            if (!found || outranks(i, best)) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          r.status = ST_NO_SLOT;
        end else begin
          r.chosen = 4'(best);
          if (!(t_load[best] < cur_load_limit && t_active[best] < cur_max_active)) begin
            r.status = ST_OVERLOAD;
          end else begin
            t_active[best] = 16'(t_active[best] + 16'd1);
            t_load[best] = load_for(t_active[best]);
            t_disp[best] = t_disp[best] + 32'd1;
            sc = (weighted_score(best) + 250) / 500;
            r.accepted = 1'b1;
            r.status = ST_OK;
            r.conf = (sc > 65536) ? 17'd65536 : 17'(sc);
            r.est_time = t_time[best];
            r.est_qual = t_qual[best];
          end
        end
      end
      KIND_COMPLETE: begin
        if (!t_valid[s]) begin
          r.status = ST_NOT_REG;
        end else begin
          t_time[s] = smooth(t_time[s], j.tval);
          t_qual[s] = 16'(smooth(24'(t_qual[s]), 24'(j.qval)));
          if (t_done[s] != 32'hFFFF_FFFF) t_done[s] = t_done[s] + 32'd1;
          if (t_active[s] > 0) t_active[s] = 16'(t_active[s] - 16'd1);
          num = longint'(t_ratio[s]) * (longint'(t_done[s]) - 1)
              + (j.ok ? 65536 : 0) + t_done[s] / 2;
          num = num / t_done[s];
          t_ratio[s] = (num > 65535) ? 16'hFFFF : 16'(num);
          t_load[s] = load_for(t_active[s]);
          r.accepted = 1'b1;
        end
      end
      KIND_REGISTER: begin
        t_valid[s] = 1'b1;
        t_caps[s] = j.mask;
        t_open[s] = j.avail;
        t_time[s] = j.tval;
        t_qual[s] = j.qval;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic job_t make_job(logic [1:0] k, logic [3:0] sl, logic [2:0] m, logic av,
                                    logic [23:0] tv, logic [15:0] qv, logic ok);
    job_t j;
    j = '{k, sl, m, av, tv, qv, ok};
    return j;
  endfunction

  // Mostly realistic traffic: registers, dispatches and completions
  function automatic job_t random_job();
    job_t j;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    j.kind = (pick < 42) ? KIND_DISPATCH : (pick < 75) ? KIND_COMPLETE :
             (pick < 94) ? KIND_REGISTER : KIND_NOP;
    j.slot = 4'($urandom_range(0, 15));
    j.mask = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'(3'd1 << $urandom_range(0, 2));
    j.avail = ($urandom_range(0, 4) != 0);
    j.tval = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30000));
    j.qval = 16'($urandom);
    j.ok = ($urandom_range(0, 3) != 0);
    return j;
  endfunction

  // Track acceptances and predict the verdict of each accepted job
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      append_verdict(dispatch_outcome(make_job(in_kind, in_slot, in_modality_mask,
        in_available, in_time_value, in_quality_value, in_task_ok)));
      jobs_taken <= jobs_taken + 1;
    end
  end

  // Driver: advance to the next job once the current transaction is taken
  always @(negedge clk) begin
    job_t j;
    if (rst_n && (jobs_sent == jobs_taken)) begin
      if (pending_jobs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        j = pending_jobs.pop_front();
        in_valid <= 1'b1;
        in_kind <= j.kind;
        in_slot <= j.slot;
        in_modality_mask <= j.mask;
        in_available <= j.avail;
        in_time_value <= j.tval;
        in_quality_value <= j.qval;
        in_task_ok <= j.ok;
        jobs_sent <= jobs_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: compare each result transaction against the oldest expectation
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with no job outstanding");
        failed = 1;
      end else begin
        e = expected_verdicts.pop_front();
        if (out_accepted !== e.accepted) begin
          $error("accepted: expected %0d actual %0d", e.accepted, out_accepted);
          failed = 1;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          failed = 1;
        end
        if (out_chosen_slot !== e.chosen) begin
          $error("chosen_slot: expected %0d actual %0d", e.chosen, out_chosen_slot);
          failed = 1;
        end
        if (out_confidence !== e.conf) begin
          $error("confidence: expected %0d actual %0d", e.conf, out_confidence);
          failed = 1;
        end
        if (out_est_time !== e.est_time) begin
          $error("est_time: expected %0d actual %0d", e.est_time, out_est_time);
          failed = 1;
        end
        if (out_est_quality !== e.est_qual) begin
          $error("est_quality: expected %0d actual %0d", e.est_qual, out_est_quality);
          failed = 1;
        end
      end
    end
  end

  // Watchdog: stop if no transaction moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STRATEGY:   cur_strategy = value[2:0];
      CFG_LOAD_LIMIT: cur_load_limit = value;
      default:        cur_max_active = value[15:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued job has been taken and answered
  task automatic drain();
    while (pending_jobs.size() != 0 || jobs_sent != jobs_taken || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    logic [2:0]  strat_set[8] = '{STRAT_QUALITY, STRAT_LATENCY, STRAT_LOAD, STRAT_FEWEST,
                                  3'd7, STRAT_SCORE, STRAT_QUALITY, STRAT_SCORE};
    logic [16:0] limit_set[8] = '{17'd65536, 17'd30000, 17'd0, 17'd52429,
                                  17'd65536, 17'd1, 17'd40000, 17'd65535};
    logic [16:0] active_set[8] = '{17'd1, 17'd65535, 17'd4, 17'd0,
                                   17'd3, 17'd8, 17'd2, 17'd65535};
    int unsigned idle_mode[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{38, 38}};
    cur_strategy = STRAT_SCORE;
    cur_load_limit = 17'd52429;
    cur_max_active = 16'd4;
    for (int i = 0; i < NSLOT; i++) begin
      t_valid[i] = '0; t_caps[i] = '0; t_open[i] = '0; t_active[i] = '0; t_done[i] = '0;
      t_time[i] = '0; t_qual[i] = '0; t_ratio[i] = '0; t_load[i] = '0; t_disp[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening under reset configuration
    append_job(make_job(KIND_DISPATCH, 4'd0, 3'd0, 1'b0, 24'd0, 16'd0, 1'b0));
    append_job(make_job(KIND_COMPLETE, 4'd5, 3'd7, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1));
    append_job(make_job(KIND_NOP, 4'hF, 3'd7, 1'b1, 24'hFFFFFF, 16'hFFFF, 1'b1));
    append_job(make_job(KIND_REGISTER, 4'd0, 3'd4, 1'b1, 24'd0, 16'hFFFF, 1'b0));
    append_job(make_job(KIND_REGISTER, 4'd15, 3'd1, 1'b1, 24'hFFFFFF, 16'd0, 1'b0));
    append_job(make_job(KIND_REGISTER, 4'd3, 3'd2, 1'b0, 24'd100, 16'd100, 1'b0));
    append_job(make_job(KIND_REGISTER, 4'd7, 3'd7, 1'b1, 24'd2000, 16'd30000, 1'b0));
    append_job(make_job(KIND_REGISTER, 4'd8, 3'd7, 1'b1, 24'd2000, 16'd30000, 1'b0));
    append_job(make_job(KIND_DISPATCH, 4'd0, 3'd2, 1'b0, 24'd0, 16'd0, 1'b0));
    append_job(make_job(KIND_DISPATCH, 4'd0, 3'd1, 1'b0, 24'd0, 16'd0, 1'b0));
    for (int i = 0; i < 5; i++)
      append_job(make_job(KIND_DISPATCH, 4'd0, 3'd4, 1'b0, 24'd0, 16'd0, 1'b0));
    append_job(make_job(KIND_COMPLETE, 4'd0, 3'd0, 1'b0, 24'hFFFFFF, 16'hFFFF, 1'b1));
    append_job(make_job(KIND_COMPLETE, 4'd0, 3'd0, 1'b0, 24'd0, 16'd0, 1'b0));
    append_job(make_job(KIND_COMPLETE, 4'd7, 3'd0, 1'b0, 24'd500, 16'd60000, 1'b1));
    append_job(make_job(KIND_REGISTER, 4'd0, 3'd7, 1'b1, 24'd25600, 16'd1, 1'b0));
    append_job(make_job(KIND_DISPATCH, 4'd0, 3'd7, 1'b0, 24'd0, 16'd0, 1'b0));
    append_job(make_job(KIND_DISPATCH, 4'd0, 3'd0, 1'b0, 24'd0, 16'd0, 1'b0));
    drain();

    // Random phases across configurations and idling modes
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_STRATEGY, 17'(strat_set[p]));
      write_reg(CFG_LOAD_LIMIT, limit_set[p]);
      write_reg(CFG_MAX_ACTIVE, active_set[p]);
      send_idle_pct = idle_mode[p % 4][0];
      recv_stall_pct = idle_mode[p % 4][1];
      for (int n = 0; n < 48; n++) append_job(random_job());
      drain();
    end

    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/wwd_pkg.sv
rtl/core/wwd_div.sv
rtl/core/weighted_worker_dispatcher_unit.sv
tb/sv/tb_weighted_worker_dispatcher_unit.sv
